>>> rtl/core/vertex_attribute_dequantizer_core_macros.svh
// Assertion macros for the vertex attribute dequantizer core.
`ifndef VERTEX_ATTRIBUTE_DEQUANTIZER_CORE_MACROS_SVH
`define VERTEX_ATTRIBUTE_DEQUANTIZER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VAD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Signal held while a valid request waits for ready.
`define VAD_ASSERT_STABLE(label, clk, rst_n, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    vld && !rdy |=> $stable(sig)) else $error(msg);
`endif

>>> rtl/core/vad_pkg.sv
// Package: types, constants and float helpers for the vertex attribute dequantizer.
`timescale 1ns / 1ps
package vad_pkg;
  localparam int unsigned NumPositions = 4;
  localparam int unsigned PosW = 2;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    TYPE_S8  = 2'd0,
    TYPE_U8  = 2'd1,
    TYPE_S16 = 2'd2,
    TYPE_U16 = 2'd3
  } comp_type_e;

  typedef enum logic [1:0] {
    REG_COMPONENT_TYPE  = 2'd0,
    REG_NORMALIZED_MODE = 2'd1,
    REG_COMPONENT_COUNT = 2'd2
  } reg_index_e;

  localparam logic [31:0] FloatPos1e30 = 32'h7149F2CA;
  localparam logic [31:0] FloatNeg1e30 = 32'hF149F2CA;
  localparam logic [31:0] FloatNegOne  = 32'hBF800000;

  // Classified request passed from front to back.
  typedef struct packed {
    logic            neg;       // value sign
    logic [15:0]     mag;       // magnitude of integer
    logic            norm;      // divide by type max
    logic [1:0]      div_sel;   // which divisor
    logic [PosW-1:0] pos;
    logic            last;
  } work_t;

  // Exact int-to-float of a 16-bit magnitude (always exact, fits 24 bits).
  function automatic logic [31:0] int_to_float(input logic neg, input logic [15:0] mag);
    logic [4:0]  msb;
    logic [22:0] frac;
    logic [31:0] sh;
    begin
      msb = 5'd0;
      for (int i = 0; i < 16; i++) if (mag[i]) msb = 5'(i);
      sh = {16'd0, mag} << (5'd23 - msb);
      frac = sh[22:0];
      if (mag == 16'd0) int_to_float = 32'd0;
      else int_to_float = {neg, 8'(msb) + 8'd127, frac};
    end
  endfunction

  // Float ordering, no NaN present.
  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    begin
      ka = a[31] ? ~a : (a | 32'h8000_0000);
      kb = b[31] ? ~b : (b | 32'h8000_0000);
      if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) f_lt = 1'b0;
      else f_lt = ka < kb;
    end
  endfunction
endpackage

>>> rtl/core/vad_stream_if.sv
// Valid/ready stream interfaces for requests, results and register writes.
`timescale 1ns / 1ps
interface vad_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_component;
  logic        last_of_accessor;
  modport source (output valid, raw_component, last_of_accessor, input ready);
  modport sink   (input valid, raw_component, last_of_accessor, output ready);
endinterface

interface vad_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic [1:0]  component_index;
  logic [31:0] running_min_bits;
  logic [31:0] running_max_bits;
  logic        end_of_accessor;
  modport source (output valid, value_bits, component_index, running_min_bits,
                  running_max_bits, end_of_accessor, input ready);
  modport sink   (input valid, value_bits, component_index, running_min_bits,
                  running_max_bits, end_of_accessor, output ready);
endinterface

interface vad_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [2:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/vertex_attribute_dequantizer_core.sv
// Top level of the vertex attribute dequantizer.
//  channel  | dir | payload
//  in_if    | in  | raw_component, last_of_accessor
//  cfg_if   | in  | index, data (always ready)
//  out_if   | out | value, index, running min/max, end flag
// One request per cycle sustained while out_if is ready; a result passes the queue,
// divide stage, normalize stage and stats logic into the output register.
// Divide by the type maximum uses the repeating bit pattern of mag/(2^n - 1).
// Reset sets registers to defaults, clears statistics and position; stalls on out_if
// back up to in_if once the queue and the three back stages (five requests) are full.
`timescale 1ns / 1ps
module vertex_attribute_dequantizer_core #(
  parameter int unsigned QueueDepth = vad_pkg::QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  vad_in_if.sink   in_if,
  vad_cfg_if.sink  cfg_if,
  vad_out_if.source out_if
);
  import vad_pkg::*;
  logic  f_valid, f_ready, b_valid, b_ready;
  work_t f_req, b_req;

  vad_front u_front (.clk_i, .rst_ni, .in_if, .cfg_if,
    .req_valid_o(f_valid), .req_ready_i(f_ready), .req_o(f_req));
  vad_queue #(.Depth(QueueDepth)) u_queue (.clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_i(f_req),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_o(b_req));
  vad_back u_back (.clk_i, .rst_ni, .req_valid_i(b_valid), .req_ready_o(b_ready),
    .req_i(b_req), .out_if);
endmodule

>>> rtl/core/vad_front.sv
// Front end: register file, sign/magnitude split and position tracking.
`timescale 1ns / 1ps
module vad_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  vad_in_if.sink          in_if,
  vad_cfg_if.sink         cfg_if,
  output logic            req_valid_o,
  input  logic            req_ready_i,
  output vad_pkg::work_t  req_o
);
  import vad_pkg::*;

  logic [1:0]      type_q, type_d;
  logic            norm_q, norm_d;
  logic [2:0]      count_q, count_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      cnt_eff, nxt;
  logic            acc;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = req_ready_i;
  assign req_valid_o  = in_if.valid;
  assign acc = in_if.valid & req_ready_i;

  always_comb begin
    type_d = type_q; norm_d = norm_q; count_d = count_q;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_COMPONENT_TYPE:  type_d  = cfg_if.data[1:0];
        REG_NORMALIZED_MODE: norm_d  = cfg_if.data[0];
        REG_COMPONENT_COUNT: count_d = cfg_if.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_eff = (count_q < 3'd2) ? 3'd2 : ((count_q > 3'd4) ? 3'd4 : count_q);
    nxt = {1'b0, pos_q} + 3'd1;
    pos_d = pos_q;
    if (acc) begin
      if (in_if.last_of_accessor || nxt >= cnt_eff) pos_d = '0;
      else pos_d = nxt[PosW-1:0];
    end
  end

  always_comb begin
    req_o.norm    = norm_q;
    req_o.div_sel = type_q;
    req_o.pos     = pos_q;
    req_o.last    = in_if.last_of_accessor;
    case (comp_type_e'(type_q))
      TYPE_S8: begin
        req_o.neg = in_if.raw_component[7];
        req_o.mag = in_if.raw_component[7] ? 16'(9'h100 - {1'b0, in_if.raw_component[7:0]})
                                           : {8'd0, in_if.raw_component[7:0]};
      end
      TYPE_U8: begin
        req_o.neg = 1'b0;
        req_o.mag = {8'd0, in_if.raw_component[7:0]};
      end
      TYPE_S16: begin
        req_o.neg = in_if.raw_component[15];
        req_o.mag = in_if.raw_component[15] ? (16'd0 - in_if.raw_component)
                                            : in_if.raw_component;
      end
      default: begin
        req_o.neg = 1'b0;
        req_o.mag = in_if.raw_component;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= 2'd1; norm_q <= 1'b0; count_q <= 3'd3; pos_q <= '0;
    end else begin
      type_q <= type_d; norm_q <= norm_d; count_q <= count_d; pos_q <= pos_d;
    end
  end
endmodule

>>> rtl/core/vad_queue.sv
// Two-entry request queue between front and back.
`timescale 1ns / 1ps
module vad_queue #(
  parameter int unsigned Depth = vad_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  vad_pkg::work_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output vad_pkg::work_t pop_o
);
  import vad_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  work_t           mem_q [Depth];
  logic [AW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [AW:0]     cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != (AW+1)'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_o        = mem_q[rp_q];
  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  always_comb begin
    wp_d = wp_q; rp_d = rp_q; cnt_d = cnt_q;
    if (push) wp_d = (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
    if (pop)  rp_d = (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= push_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end
endmodule

>>> rtl/core/vad_back.sv
// Back end: normalize divide pipeline, min/max stores and output register.
`timescale 1ns / 1ps
module vad_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  vad_pkg::work_t  req_i,
  vad_out_if.source       out_if
);
  import vad_pkg::*;

  // Every divisor is 2^n - 1, so mag/D for mag < D is the n-bit pattern of mag
  // repeated after the binary point. Stage 1 builds 48 such fraction bits,
  // stage 2 normalizes and rounds them.
  logic            s1_v_q;
  work_t           s1_q;
  logic [31:0]     s1_int_q;     // exact float when not normalized
  logic [47:0]     s1_frac_q;    // fraction bits of mag/D
  logic            s1_big_q;     // mag above D, below -1.0
  logic            s2_v_q;
  logic [31:0]     s2_val_q;
  work_t           s2_q;
  logic [31:0]     min_q [NumPositions];
  logic [31:0]     max_q [NumPositions];
  logic            adv1, adv2, ovld_q;
  logic [48:0]     rep7;
  logic [59:0]     rep15;
  logic [47:0]     frac;
  logic            big;
  logic [31:0]     res_val, nmin, nmax;

  // Output register accepts while empty or drained; back pressure flows upstream.
  assign adv2 = s2_v_q & (~ovld_q | out_if.ready);
  assign adv1 = s1_v_q & (~s2_v_q | adv2);
  assign req_ready_o = ~s1_v_q | adv1;

  always_comb begin
    rep7  = {7{req_i.mag[6:0]}};
    rep15 = {4{req_i.mag[14:0]}};
    big   = 1'b0;
    case (comp_type_e'(req_i.div_sel))
      TYPE_S8: begin
        frac = rep7[48:1];
        big  = req_i.mag[7];
      end
      TYPE_U8: frac = {6{req_i.mag[7:0]}};
      TYPE_S16: begin
        frac = rep15[59:12];
        big  = req_i.mag[15];
      end
      default: frac = {3{req_i.mag}};
    endcase
  end

  // Stage 2 logic: normalize the fraction and round to single.
  logic [3:0]  lz;
  logic [47:0] nf;
  logic [24:0] mr;
  logic [7:0]  ex;
  logic [31:0] qf;
  always_comb begin
    lz = 4'd0;
    for (int i = 15; i >= 0; i--) if (s1_frac_q[47 - i]) lz = 4'(i);
    nf = s1_frac_q << lz;
    // periodic expansion never ties, so the guard bit alone decides rounding
    mr = {1'b0, nf[47:24]} + 25'(nf[23]);
    ex = 8'd126 - 8'(lz);
    if (mr[24]) begin ex = ex + 8'd1; mr = mr >> 1; end
    if (s1_q.neg && s1_big_q) qf = FloatNegOne;   // below -1.0, clamped
    else if (s1_frac_q == '0) qf = 32'd0;
    else qf = {s1_q.neg, ex, mr[22:0]};
    if (s1_q.norm) res_val = qf;
    else res_val = s1_int_q;
  end

  always_comb begin
    nmin = f_lt(s2_val_q, min_q[s2_q.pos]) ? s2_val_q : min_q[s2_q.pos];
    nmax = f_lt(max_q[s2_q.pos], s2_val_q) ? s2_val_q : max_q[s2_q.pos];
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o) begin
      s1_q <= req_i;
      s1_int_q <= int_to_float(req_i.neg, req_i.mag);
      s1_frac_q <= frac;
      s1_big_q <= big;
    end
    if (adv1) begin s2_q <= s1_q; s2_val_q <= res_val; end
    if (adv2) begin
      out_if.value_bits <= s2_val_q;
      out_if.component_index <= s2_q.pos;
      out_if.running_min_bits <= nmin;
      out_if.running_max_bits <= nmax;
      out_if.end_of_accessor <= s2_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; ovld_q <= 1'b0;
      for (int i = 0; i < NumPositions; i++) begin
        min_q[i] <= FloatPos1e30; max_q[i] <= FloatNeg1e30;
      end
    end else begin
      if (req_ready_o) s1_v_q <= req_valid_i;
      if (adv1) s2_v_q <= 1'b1; else if (adv2) s2_v_q <= 1'b0;
      if (adv2) ovld_q <= 1'b1; else if (out_if.ready) ovld_q <= 1'b0;
      if (adv2) begin
        if (s2_q.last) begin
          for (int i = 0; i < NumPositions; i++) begin
            min_q[i] <= FloatPos1e30; max_q[i] <= FloatNeg1e30;
          end
        end else begin
          min_q[s2_q.pos] <= nmin; max_q[s2_q.pos] <= nmax;
        end
      end
    end
  end
  assign out_if.valid = ovld_q;
endmodule

>>> rtl/core/vad_checker.sv
// Port-level checks for the dequantizer core, bound to the top level.
`timescale 1ns / 1ps
`include "vertex_attribute_dequantizer_core_macros.svh"
module vad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value_bits,
  input logic [31:0] min_bits,
  input logic [31:0] max_bits,
  input logic [1:0]  idx
);
  `VAD_ASSERT(a_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(value_bits), "result dropped")
  `VAD_ASSERT_STABLE(a_hold_idx, clk_i, rst_ni, out_valid, out_ready, idx, "index changed while stalled")
  `VAD_ASSERT(a_min_sign, clk_i, rst_ni, out_valid && !value_bits[31] |-> !(min_bits[31] == 1'b0 && min_bits > value_bits), "min above value")
  `VAD_ASSERT(a_max_sign, clk_i, rst_ni, out_valid && value_bits[31] |-> !(max_bits[31] == 1'b1 && max_bits > value_bits), "max below value")
endmodule

bind vertex_attribute_dequantizer_core vad_checker u_vad_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_if.valid), .out_ready(out_if.ready),
  .value_bits(out_if.value_bits), .min_bits(out_if.running_min_bits),
  .max_bits(out_if.running_max_bits), .idx(out_if.component_index));

>>> dv/tb_vertex_attribute_dequantizer_core.sv
// Self-checking testbench for the vertex attribute dequantizer core.
`timescale 1ns / 1ps
module tb_vertex_attribute_dequantizer_core;
  import vad_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;  // index past the register list
  localparam int unsigned SettleCycles = 8;

  typedef enum logic [1:0] {
    K_DATA,
    K_CFG,
    K_DRAIN
  } job_kind_e;

  typedef struct {
    job_kind_e   kind;
    logic [15:0] raw;
    logic        last;
    logic [1:0]  idx;
    logic [2:0]  data;
  } job_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  pos;
    logic [31:0] vmin;
    logic [31:0] vmax;
    logic        eoa;
  } attr_res_t;

  logic clk_i;
  logic rst_ni;

  vad_in_if  in_if ();
  vad_cfg_if cfg_if ();
  vad_out_if out_if ();

  vertex_attribute_dequantizer_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .cfg_if(cfg_if.sink),
    .out_if(out_if.source)
  );

  job_t      job_q[$];
  attr_res_t attr_expected_q[$];

  // shadow registers and statistics
  logic [1:0]  sh_type;
  logic        sh_norm;
  logic [2:0]  sh_count;
  logic [31:0] min_store[4];
  logic [31:0] max_store[4];
  logic [1:0]  pos_cnt;

  int unsigned mismatches;
  int unsigned n_results;
  int unsigned n_accessors;
  int unsigned n_cfg;
  logic        in_fire;
  logic        cfg_fire;
  logic        calm;
  int unsigned gap;
  int unsigned rdy_hold;
  int unsigned settle;
  logic        nx_in_valid;
  logic        nx_cfg_valid;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] real_to_single(input real r);
    logic [63:0] b;
    logic [30:0] keep;
    logic [28:0] rem;
    begin
      if (r == 0.0) return 32'd0;
      b = $realtobits(r);
      keep = {8'(b[62:52] - 11'd1023 + 11'd127), b[51:29]};
      rem = b[28:0];
      if ((rem > 29'h1000_0000) || ((rem == 29'h1000_0000) && keep[0])) keep = keep + 31'd1;
      return {b[63], keep};
    end
  endfunction

  function automatic real single_to_real(input logic [31:0] f);
    begin
      if (f[30:0] == 31'd0) return 0.0;
      return $bitstoreal({f[31], 11'(f[30:23]) - 11'd127 + 11'd1023, f[22:0], 29'd0});
    end
  endfunction

  function automatic void clear_stats();
    for (int i = 0; i < 4; i++) begin
      min_store[i] = FloatPos1e30;
      max_store[i] = FloatNeg1e30;
    end
    pos_cnt = 2'd0;
  endfunction

  function automatic attr_res_t dequant_step(input logic [15:0] raw, input logic last);
    attr_res_t r;
    int        s;
    real       v;
    real       d;
    real       q;
    real       fl;
    real       vf;
    logic [2:0] cnt;
    logic [2:0] nxt;
    logic [31:0] vb;
    begin
      cnt = (sh_count < 3'd2) ? 3'd2 : (sh_count > 3'd4) ? 3'd4 : sh_count;
      case (comp_type_e'(sh_type))
        TYPE_S8: begin
          s = raw[7] ? int'(raw[7:0]) - 256 : int'(raw[7:0]);
          d = 127.0;
          fl = -1.0;
        end
        TYPE_U8: begin
          s = int'(raw[7:0]);
          d = 255.0;
          fl = 0.0;
        end
        TYPE_S16: begin
          s = raw[15] ? int'(raw) - 65536 : int'(raw);
          d = 32767.0;
          fl = -1.0;
        end
        default: begin
          s = int'(raw);
          d = 65535.0;
          fl = 0.0;
        end
      endcase
      v = s;
      if (sh_norm) begin
        // double then single rounding is exact for a quotient this short
        q = v / d;
        v = (fl < q) ? q : fl;
      end
      vb = real_to_single(v);
      vf = single_to_real(vb);
      if (vf < single_to_real(min_store[pos_cnt])) min_store[pos_cnt] = vb;
      if (single_to_real(max_store[pos_cnt]) < vf) max_store[pos_cnt] = vb;
      r.value = vb;
      r.pos = pos_cnt;
      r.vmin = min_store[pos_cnt];
      r.vmax = max_store[pos_cnt];
      r.eoa = last;
      nxt = {1'b0, pos_cnt} + 3'd1;
      pos_cnt = (nxt >= cnt) ? 2'd0 : nxt[1:0];
      if (last) clear_stats();
      return r;
    end
  endfunction

  function automatic void push_data(input logic [15:0] raw, input logic last);
    job_t j;
    j.kind = K_DATA;
    j.raw = raw;
    j.last = last;
    j.idx = '0;
    j.data = '0;
    job_q.push_back(j);
  endfunction

  function automatic void push_cfg(input logic [1:0] idx, input logic [2:0] data);
    job_t j;
    j.kind = K_CFG;
    j.raw = '0;
    j.last = 1'b0;
    j.idx = idx;
    j.data = data;
    job_q.push_back(j);
  endfunction

  function automatic void push_drain();
    job_t j;
    j.kind = K_DRAIN;
    j.raw = '0;
    j.last = 1'b0;
    j.idx = '0;
    j.data = '0;
    job_q.push_back(j);
  endfunction

  function automatic void push_setting(input logic [1:0] t, input logic n, input logic [2:0] c);
    push_drain();
    push_cfg(REG_COMPONENT_TYPE, {1'($urandom), t});
    push_cfg(REG_NORMALIZED_MODE, {2'($urandom), n});
    push_cfg(REG_COMPONENT_COUNT, c);
  endfunction

  // monitor: prediction on accepted requests, checking on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
      cfg_fire <= 1'b0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      cfg_fire <= cfg_if.valid && cfg_if.ready;
      if (in_if.valid && in_if.ready)
        attr_expected_q.push_back(dequant_step(in_if.raw_component, in_if.last_of_accessor));
      if (cfg_if.valid && cfg_if.ready) begin
        n_cfg++;
        case (cfg_if.index)
          REG_COMPONENT_TYPE:  sh_type = cfg_if.data[1:0];
          REG_NORMALIZED_MODE: sh_norm = cfg_if.data[0];
          REG_COMPONENT_COUNT: sh_count = cfg_if.data;
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        attr_res_t got;
        attr_res_t exp_r;
        got = {out_if.value_bits, out_if.component_index, out_if.running_min_bits,
               out_if.running_max_bits, out_if.end_of_accessor};
        n_results++;
        if (got.eoa) n_accessors++;
        if (attr_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = attr_expected_q.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp val %h pos %0d min %h max %h end %b / got val %h pos %0d min %h max %h end %b",
                       exp_r.value, exp_r.pos, exp_r.vmin, exp_r.vmax, exp_r.eoa,
                       got.value, got.pos, got.vmin, got.vmax, got.eoa);
          end
        end
      end
    end
  end

  // driver: requests, register writes and result backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      calm = (job_q.size() < 150);
      if (calm) begin
        out_if.ready <= 1'b1;
      end else if (rdy_hold > 0) begin
        rdy_hold--;
      end else begin
        rdy_hold = $urandom_range(1, 15);
        out_if.ready <= ($urandom_range(0, 2) != 0);
      end

      nx_in_valid = in_if.valid && !in_fire;
      nx_cfg_valid = cfg_if.valid && !cfg_fire;
      if (!nx_in_valid && !nx_cfg_valid) begin
        if (gap > 0) begin
          gap--;
        end else if (job_q.size() > 0) begin
          case (job_q[0].kind)
            K_DATA: begin
              nx_in_valid = 1'b1;
              in_if.raw_component <= job_q[0].raw;
              in_if.last_of_accessor <= job_q[0].last;
              void'(job_q.pop_front());
              if (!calm && ($urandom_range(0, 5) == 0)) gap = $urandom_range(1, 15);
            end
            K_CFG: begin
              nx_cfg_valid = 1'b1;
              cfg_if.index <= job_q[0].idx;
              cfg_if.data <= job_q[0].data;
              void'(job_q.pop_front());
            end
            default: begin
              // idle window: everything back, then a settling pause for the pipe
              if (attr_expected_q.size() != 0) begin
                settle = 0;
              end else if (settle >= SettleCycles) begin
                settle = 0;
                void'(job_q.pop_front());
              end else begin
                settle++;
              end
            end
          endcase
        end
      end
      in_if.valid <= nx_in_valid;
      cfg_if.valid <= nx_cfg_valid;
    end
  end

  initial begin
    logic [15:0] raw;
    logic [2:0]  cnt;
    int unsigned len;
    in_if.valid = 1'b0;
    in_if.raw_component = '0;
    in_if.last_of_accessor = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_COMPONENT_TYPE;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    sh_type = TYPE_U8;
    sh_norm = 1'b0;
    sh_count = 3'd3;
    clear_stats();
    mismatches = 0;
    n_results = 0;
    n_accessors = 0;
    n_cfg = 0;
    gap = 0;
    rdy_hold = 0;
    settle = 0;
    calm = 1'b0;
    rst_ni = 1'b0;

    // directed: reset setting first, high byte ignored on 8-bit types
    push_data(16'hAB80, 1'b0);
    push_data(16'hFFFF, 1'b0);
    push_data(16'h0000, 1'b0);
    push_data(16'h00FF, 1'b1);
    push_setting(TYPE_S8, 1'b1, 3'd3);
    push_data(16'h0080, 1'b0);
    push_data(16'h0081, 1'b0);
    push_data(16'h007F, 1'b0);
    push_data(16'hFF00, 1'b0);
    push_data(16'h00FF, 1'b1);
    push_setting(TYPE_S16, 1'b1, 3'd4);
    push_data(16'h8000, 1'b0);
    push_data(16'h8001, 1'b0);
    push_data(16'h7FFF, 1'b0);
    push_data(16'h0001, 1'b0);
    push_data(16'hFFFF, 1'b1);
    push_setting(TYPE_U16, 1'b1, 3'd0);
    push_data(16'hFFFF, 1'b0);
    push_data(16'h0001, 1'b0);
    push_data(16'h0000, 1'b0);
    // index past the list, then count lowered mid-element
    push_drain();
    push_cfg(RegUnused, 3'd7);
    push_setting(TYPE_S16, 1'b0, 3'd7);
    push_data(16'h8000, 1'b0);
    push_data(16'h7FFF, 1'b0);
    push_data(16'h1234, 1'b0);
    push_setting(TYPE_S16, 1'b0, 3'd2);
    push_data(16'h0042, 1'b0);
    push_data(16'hFFFE, 1'b1);

    // random phases, one per setting, counts 0..7 included
    for (int p = 0; p < 24; p++) begin
      cnt = (p < 8) ? 3'(p) : 3'($urandom_range(2, 4));
      push_setting(2'(p % 4), 1'((p / 4) % 2), cnt);
      if (p % 6 == 5) push_cfg(RegUnused, 3'($urandom));
      len = $urandom_range(30, 60);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0: raw = 16'h0000;
          1: raw = 16'hFFFF;
          2: raw = {$urandom_range(0, 1) ? 8'h80 : 8'h7F, 8'($urandom)};
          3: raw = {8'($urandom), $urandom_range(0, 1) ? 8'h80 : 8'h7F};
          default: raw = 16'($urandom);
        endcase
        push_data(raw, ($urandom_range(0, 39) == 0) || (k == len - 1 && p % 3 == 0));
      end
    end
    // final stretch at the widest setting, with no idling
    push_setting(TYPE_S16, 1'b1, 3'd4);
    for (int k = 0; k < 140; k++) push_data(16'($urandom), ($urandom_range(0, 49) == 0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (job_q.size() == 0 && !in_if.valid && !cfg_if.valid);
    wait (attr_expected_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (attr_expected_q.size() != 0) mismatches++;
    $display("Checked %0d results over %0d finished accessors, %0d register writes,",
             n_results, n_accessors, n_cfg);
    $display("all four component types, both modes and counts 0 to 7; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end
endmodule
